// ===== hdl/heater_pid_with_bed_bang_bang_unit_macros.svh =====
// Assertion macros for the heater PID block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef HEATER_PID_WITH_BED_BANG_BANG_UNIT_MACROS_SVH
`define HEATER_PID_WITH_BED_BANG_BANG_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HPBB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define HPBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hpbb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the heater PID / bed thermostat block.
// No dependencies.
package hpbb_pkg;

    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 24;
    localparam int SPEED_W    = 16;
    localparam int RAW_W      = 14;
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int LIMIT_W    = 16;

    // shared multiplier: signed 25 x signed 18
    localparam int MA_W       = 25;
    localparam int MB_W       = 18;
    localparam int MP_W       = MA_W + MB_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BED_TARGET = 3'd6;

    // derivative filter weights, 0.05 / 0.95 in 16 fraction bits
    localparam logic signed [MB_W-1:0] COEF_NEW = 18'sd3277;
    localparam logic signed [MB_W-1:0] COEF_OLD = 18'sd62259;

    typedef struct packed {
        logic signed [TEMP_W-1:0] hotend_temp;
        logic [SPEED_W-1:0]       extrude_speed;
        logic [RAW_W-1:0]         bed_raw;
        logic [TIME_W-1:0]        time_ms;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] heater_duty;
        logic              band_override;
        logic              bed_heater_on;
        logic              bed_updated;
    } t_out_item;

endpackage

// ===== hdl/hpbb_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per request.
// Payload type is supplied by the instantiating level (types from hpbb_pkg).
interface hpbb_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/hpbb_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on hpbb_pkg for operand widths.
module hpbb_mul (
    input  logic                              i_clk,
    input  logic signed [hpbb_pkg::MA_W-1:0]  i_a,
    input  logic signed [hpbb_pkg::MB_W-1:0]  i_b,
    output logic signed [hpbb_pkg::MP_W-1:0]  o_p
);
    logic signed [hpbb_pkg::MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== hdl/heater_pid_with_bed_bang_bang_unit.sv =====
`timescale 1ns / 1ps
// Top level: hotend PID with out-of-band bang-bang and a timed bed thermostat.
// Depends on hpbb_pkg, hpbb_chan_if, hpbb_mul and the assertion macro header.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-------------
//  i_in     | in  | hotend_temp, extrude_speed, bed_raw, time_ms  | valid/ready
//  o_out    | out | heater_duty, band_override, bed_heater_on,    | valid/ready
//           |     | bed_updated                                   |
//  i_cfg_*  | in  | register index, write data                    | write enable
//
// In band a request passes from acceptance through error, band check, nine steps of
// the one shared 25x18 multiplier and accumulator, and result; out of band it skips
// the multiply steps. Ready is high only while no request is in progress.
// The result register holds while the sink stalls; a new request may be taken
// meanwhile, and its final step waits until the held result is taken.
// Synchronous active-low reset restores register defaults and clears control and history state.
`include "heater_pid_with_bed_bang_bang_unit_macros.svh"
module heater_pid_with_bed_bang_bang_unit #(
    parameter int BED_INTERVAL_MS = 5000,
    parameter int ERROR_BAND      = 160
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hpbb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [hpbb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    hpbb_chan_if.sink                            i_in,
    hpbb_chan_if.source                          o_out
);
    localparam int ACC_W = 56;
    localparam int ERR_W = hpbb_pkg::TEMP_W + 1;
    localparam int RAWD_W = 41;

    // step codes: operand pair issued to the multiplier in that step
    localparam logic [3:0] STEP_RAW    = 4'd0;
    localparam logic [3:0] STEP_DF_LO  = 4'd1;
    localparam logic [3:0] STEP_DF_HI  = 4'd2;
    localparam logic [3:0] STEP_RAW_LO = 4'd3;
    localparam logic [3:0] STEP_RAW_HI = 4'd4;
    localparam logic [3:0] STEP_P      = 4'd5;
    localparam logic [3:0] STEP_FF     = 4'd6;
    localparam logic [3:0] STEP_I      = 4'd7;
    localparam logic [3:0] STEP_LAST   = 4'd8;

    localparam logic signed [ERR_W-1:0] C_BAND = ERR_W'(ERROR_BAND);
    localparam logic [hpbb_pkg::TIME_W-1:0] C_INTERVAL = hpbb_pkg::TIME_W'(BED_INTERVAL_MS);
    localparam logic signed [ACC_W-1:0] C_ROUND = 56'sd32768;

    typedef enum logic [2:0] {S_IDLE, S_ERR, S_BAND, S_MUL, S_FIN} t_state;

    // configuration registers
    logic signed [hpbb_pkg::TEMP_W-1:0] r_sp;
    logic [hpbb_pkg::GAIN_W-1:0]        r_gp, r_gi, r_gd, r_gs;
    logic [hpbb_pkg::LIMIT_W-1:0]       r_lim;
    logic [hpbb_pkg::RAW_W-1:0]         r_bt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_gp  <= 24'd349091;
            r_gi  <= 24'd931;
            r_gd  <= '0;
            r_gs  <= 24'd1280;
            r_lim <= 16'd1122;
            r_bt  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hpbb_pkg::REG_SETPOINT:   r_sp  <= i_cfg_data[hpbb_pkg::TEMP_W-1:0];
                hpbb_pkg::REG_GAIN_P:     r_gp  <= i_cfg_data;
                hpbb_pkg::REG_GAIN_I:     r_gi  <= i_cfg_data;
                hpbb_pkg::REG_GAIN_D:     r_gd  <= i_cfg_data;
                hpbb_pkg::REG_GAIN_SPEED: r_gs  <= i_cfg_data;
                hpbb_pkg::REG_INT_LIMIT:  r_lim <= i_cfg_data[hpbb_pkg::LIMIT_W-1:0];
                hpbb_pkg::REG_BED_TARGET: r_bt  <= i_cfg_data[hpbb_pkg::RAW_W-1:0];
                default: ;
            endcase
        end
    end

    t_state                             r_state;
    logic [3:0]                         r_step;
    logic signed [hpbb_pkg::TEMP_W-1:0] r_temp;
    logic [hpbb_pkg::SPEED_W-1:0]       r_speed;
    logic [hpbb_pkg::RAW_W-1:0]         r_bed_raw;
    logic [hpbb_pkg::TIME_W-1:0]        r_now;
    logic signed [ERR_W-1:0]            r_err, r_dt;
    logic [hpbb_pkg::LIMIT_W-1:0]       r_ia;
    logic signed [hpbb_pkg::TEMP_W-1:0] r_last_temp;
    logic signed [31:0]                 r_df;
    logic                               r_pend;
    logic [hpbb_pkg::TIME_W-1:0]        r_last_bed;
    logic                               r_bed_drive;
    logic signed [RAWD_W-1:0]           r_raw;
    logic signed [ACC_W-1:0]            r_acc;
    logic [hpbb_pkg::DUTY_W-1:0]        r_duty_ovr;
    logic                               r_ovr;
    logic                               r_out_valid;
    hpbb_pkg::t_out_item                r_out;

    logic signed [hpbb_pkg::MA_W-1:0]   mul_a;
    logic signed [hpbb_pkg::MB_W-1:0]   mul_b;
    logic signed [hpbb_pkg::MP_W-1:0]   prod;

    hpbb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    logic signed [ERR_W-1:0]          n_err, n_dt;
    logic                             above, below;
    logic [hpbb_pkg::LIMIT_W-1:0]     ia_base, n_ia;
    logic signed [ERR_W:0]            ia_sum;
    logic signed [ACC_W-1:0]          prod_ext, prod_sh24, prod_sh4;
    logic                             d_fits;
    logic signed [31:0]               d_sat;
    logic [hpbb_pkg::DUTY_W-1:0]      pid_duty;
    logic [hpbb_pkg::TIME_W-1:0]      elapsed;
    logic                             bed_due;
    logic                             out_free;

    always_comb begin
        n_err = ERR_W'(r_sp) - ERR_W'(r_temp);
        n_dt  = ERR_W'(r_temp) - ERR_W'(r_last_temp);
        above = r_err > C_BAND;
        below = r_err < -C_BAND;

        // integral restarts from zero after a band excursion
        ia_base = r_pend ? '0 : r_ia;
        ia_sum  = $signed({2'b00, ia_base}) + (ERR_W + 1)'(r_err);
        if (ia_sum[ERR_W]) begin
            n_ia = '0;
        end else if (ia_sum > $signed({2'b00, r_lim})) begin
            n_ia = r_lim;
        end else begin
            n_ia = ia_sum[hpbb_pkg::LIMIT_W-1:0];
        end

        unique case (r_step)
            STEP_RAW: begin
                mul_a = {1'b0, r_gd};
                mul_b = hpbb_pkg::MB_W'(r_dt);
            end
            STEP_DF_LO: begin
                mul_a = {1'b0, r_df[23:0]};
                mul_b = hpbb_pkg::COEF_OLD;
            end
            STEP_DF_HI: begin
                mul_a = {{17{r_df[31]}}, r_df[31:24]};
                mul_b = hpbb_pkg::COEF_OLD;
            end
            STEP_RAW_LO: begin
                mul_a = {1'b0, r_raw[23:0]};
                mul_b = hpbb_pkg::COEF_NEW;
            end
            STEP_RAW_HI: begin
                mul_a = {{8{r_raw[RAWD_W-1]}}, r_raw[RAWD_W-1:24]};
                mul_b = hpbb_pkg::COEF_NEW;
            end
            STEP_P: begin
                mul_a = {1'b0, r_gp};
                mul_b = hpbb_pkg::MB_W'(r_err);
            end
            STEP_FF: begin
                mul_a = {1'b0, r_gs};
                mul_b = {2'b00, r_speed};
            end
            STEP_I: begin
                mul_a = {1'b0, r_gi};
                mul_b = {2'b00, r_ia};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod_ext  = ACC_W'(prod);
        prod_sh24 = prod_ext <<< 24;
        prod_sh4  = prod_ext >>> 4;

        // floor(acc / 2^16) saturated to 32 bits signed
        d_fits = (&r_acc[ACC_W-1:47]) | ~(|r_acc[ACC_W-1:47]);
        if (d_fits) begin
            d_sat = r_acc[47:16];
        end else if (r_acc[ACC_W-1]) begin
            d_sat = 32'sh8000_0000;
        end else begin
            d_sat = 32'sh7FFF_FFFF;
        end

        if (r_acc[ACC_W-1]) begin
            pid_duty = '0;
        end else if (|r_acc[ACC_W-1:20]) begin
            pid_duty = '1;
        end else begin
            pid_duty = r_acc[19:12];
        end

        elapsed  = r_now - r_last_bed;
        bed_due  = elapsed >= C_INTERVAL;
        out_free = !r_out_valid || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_RAW;
            r_ia        <= '0;
            r_last_temp <= '0;
            r_df        <= '0;
            r_pend      <= 1'b0;
            r_last_bed  <= '0;
            r_bed_drive <= 1'b0;
            r_out_valid <= 1'b0;
            r_ovr       <= 1'b0;
        end else begin
            // in S_FIN the result slot is refilled instead
            if (r_out_valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_temp    <= i_in.data.hotend_temp;
                        r_speed   <= i_in.data.extrude_speed;
                        r_bed_raw <= i_in.data.bed_raw;
                        r_now     <= i_in.data.time_ms;
                        r_state   <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_dt    <= n_dt;
                    r_state <= S_BAND;
                end
                S_BAND: begin
                    if (above || below) begin
                        r_duty_ovr <= above ? '1 : '0;
                        r_ovr      <= 1'b1;
                        r_pend     <= 1'b1;
                        r_state    <= S_FIN;
                    end else begin
                        r_ia        <= n_ia;
                        r_pend      <= 1'b0;
                        r_ovr       <= 1'b0;
                        r_last_temp <= r_temp;
                        r_step      <= STEP_RAW;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    // product of the previous step arrives now
                    unique case (r_step)
                        STEP_RAW: ;
                        STEP_DF_LO: begin
                            r_raw <= prod[RAWD_W-1:0];
                            r_acc <= C_ROUND;
                        end
                        STEP_DF_HI:  r_acc <= r_acc + prod_ext;
                        STEP_RAW_LO: r_acc <= r_acc + prod_sh24;
                        STEP_RAW_HI: r_acc <= r_acc + prod_ext;
                        STEP_P:      r_acc <= r_acc + prod_sh24;
                        STEP_FF: begin
                            // filter done: store it, start the duty sum with P - D
                            r_df  <= d_sat;
                            r_acc <= prod_ext - {{(ACC_W - 32){d_sat[31]}}, d_sat};
                        end
                        STEP_I:      r_acc <= r_acc + prod_sh4;
                        default:     r_acc <= r_acc + prod_ext;
                    endcase
                    if (r_step == STEP_LAST) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out.heater_duty      <= r_ovr ? r_duty_ovr : pid_duty;
                        r_out.band_override    <= r_ovr;
                        r_out.bed_updated      <= bed_due;
                        if (bed_due) begin
                            r_last_bed          <= r_now;
                            r_bed_drive         <= r_bed_raw < r_bt;
                            r_out.bed_heater_on <= r_bed_raw < r_bt;
                        end else begin
                            r_out.bed_heater_on <= r_bed_drive;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `HPBB_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "ready while a request is in progress")
    `HPBB_ASSERT_IMPL(a_ovr_duty_rail, i_clk, i_rst_n, o_out.valid && o_out.data.band_override, o_out.data.heater_duty == 8'd0 || o_out.data.heater_duty == 8'hFF, "override duty not at a rail")
    `HPBB_ASSERT_IMPL(a_step_range, i_clk, i_rst_n, r_state == S_MUL, r_step <= STEP_LAST, "multiply step out of range")
    `HPBB_ASSERT_IMPL(a_ovr_arms_reset, i_clk, i_rst_n, r_state == S_FIN && r_ovr, r_pend, "band excursion did not arm integral reset")

endmodule
